### rtl/mqfd_pkg.sv
// ----------------------------------------------------------------------------
// mqfd_pkg: shared types and constants for the mailbox dequeue unit
// Command codes, slot index widths, word structs and sequencer states.
// ----------------------------------------------------------------------------
package mqfd_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_RECV   = 2'd1;
  localparam logic [1:0] CMD_FILTER = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  msg_namespace;
    logic [31:0] msg_id;
    logic [63:0] payload;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic        full_error;
    logic [7:0]  out_namespace;
    logic [31:0] out_id;
    logic [63:0] out_payload;
    logic [4:0]  pending_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

### rtl/mqfd_slot_mem.sv
// ----------------------------------------------------------------------------
// mqfd_slot_mem: slot storage
// Message fields and links, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mqfd_slot_mem import mqfd_pkg::*; (
  input  logic              clk,
  input  logic              msg_we,
  input  logic [SLOT_W-1:0] msg_waddr,
  input  logic [7:0]        msg_wns,
  input  logic [31:0]       msg_wid,
  input  logic [63:0]       msg_wbody,
  input  logic              link_we,
  input  logic [SLOT_W-1:0] link_waddr,
  input  logic [SLOT_W-1:0] link_wdata,
  input  logic [SLOT_W-1:0] raddr,
  output logic [7:0]        rns,
  output logic [31:0]       rid,
  output logic [63:0]       rbody,
  output logic [SLOT_W-1:0] rlink
);

  logic [7:0]        mem_ns   [SLOT_COUNT];
  logic [31:0]       mem_id   [SLOT_COUNT];
  logic [63:0]       mem_body [SLOT_COUNT];
  logic [SLOT_W-1:0] mem_link [SLOT_COUNT];

  // write message fields and links
  always_ff @(posedge clk) begin
    if (msg_we) begin
      mem_ns[msg_waddr]   <= msg_wns;
      mem_id[msg_waddr]   <= msg_wid;
      mem_body[msg_waddr] <= msg_wbody;
    end
    if (link_we) begin
      mem_link[link_waddr] <= link_wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rns   <= mem_ns[raddr];
    rid   <= mem_id[raddr];
    rbody <= mem_body[raddr];
    rlink <= mem_link[raddr];
  end

endmodule

### rtl/mailbox_queue_filtered_dequeue_unit.sv
// ----------------------------------------------------------------------------
// mailbox_queue_filtered_dequeue_unit: linked-list mailbox with filtered receive
// Send scans slots from index 0 for the first free one; receive takes the head;
//   filtered receive walks the list from the head, reading then checking each message.
// One word at a time; each visited message uses the slot memory read port and a single compare step.
// Result waits in an output register; a new word is taken once it is gone.
// Synchronous reset clears in-use bits, head, tail, count; slot data is not cleared.
// ----------------------------------------------------------------------------
module mailbox_queue_filtered_dequeue_unit import mqfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  state_t state, state_next;
  in_word_t cur_in;
  logic [SLOT_COUNT-1:0] in_use;
  logic [SLOT_W-1:0] head_slot, tail_slot, cur, prev, scan;
  logic [CNT_W-1:0]  unread_total, k;
  logic [7:0]  rns;
  logic [31:0] rid;
  logic [63:0] rbody;
  logic [SLOT_W-1:0] rlink, raddr;
  logic msg_we, link_we;
  logic [SLOT_W-1:0] link_waddr, link_wdata;
  logic take;

  assign take     = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || out_valid;

  // read address follows the walk pointer
  assign raddr = cur;

  mqfd_slot_mem u_mem (
    .clk(clk), .msg_we(msg_we), .msg_waddr(scan),
    .msg_wns(cur_in.msg_namespace), .msg_wid(cur_in.msg_id),
    .msg_wbody(cur_in.payload), .link_we(link_we), .link_waddr(link_waddr),
    .link_wdata(link_wdata), .raddr(raddr), .rns(rns), .rid(rid),
    .rbody(rbody), .rlink(rlink)
  );

  logic match;
  assign match = (rns == cur_in.msg_namespace) && (rid == cur_in.msg_id);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory write strobes
  always_comb begin
    state_next = state;
    msg_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = tail_slot;
    link_wdata = scan;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          priority if (in_data.cmd == CMD_SEND) begin
            state_next = ST_SCAN;
          end else if ((in_data.cmd == CMD_RECV || in_data.cmd == CMD_FILTER)
                       && unread_total != '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (!in_use[scan]) begin
          msg_we     = 1'b1;
          link_we    = unread_total != '0;
          state_next = ST_DONE;
        end else if (scan == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_CHECK;
      ST_CHECK: begin
        if (cur_in.cmd == CMD_RECV || match) begin
          link_we    = k != '0;
          link_waddr = prev;
          link_wdata = rlink;
          state_next = ST_DONE;
        end else if (k + 1'b1 == unread_total) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use       <= '0;
      head_slot    <= '0;
      tail_slot    <= '0;
      unread_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cur_in   <= in_data;
            scan     <= '0;
            cur      <= head_slot;
            prev     <= '0;
            k        <= '0;
            out_data <= '0;
          end
        end
        ST_SCAN: begin
          if (!in_use[scan]) begin
            in_use[scan] <= 1'b1;
            if (unread_total == '0) begin
              head_slot <= scan;
            end
            tail_slot       <= scan;
            unread_total    <= unread_total + 1'b1;
            out_data.ok     <= 1'b1;
          end else if (scan == SLOT_W'(SLOT_COUNT - 1)) begin
            out_data.full_error <= 1'b1;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_READ: ;
        ST_CHECK: begin
          if (cur_in.cmd == CMD_RECV || match) begin
            out_data.ok            <= 1'b1;
            out_data.out_namespace <= rns;
            out_data.out_id        <= rid;
            out_data.out_payload   <= rbody;
            in_use[cur]            <= 1'b0;
            unread_total           <= unread_total - 1'b1;
            if (unread_total == CNT_W'(1)) begin
              head_slot <= '0;
              tail_slot <= '0;
            end else begin
              if (k == '0) begin
                head_slot <= rlink;
              end
              if (k + 1'b1 == unread_total) begin
                tail_slot <= prev;
              end
            end
          end else begin
            prev <= cur;
            cur  <= rlink;
            k    <= k + 1'b1;
          end
        end
        ST_DONE: begin
          out_data.pending_count <= 5'(unread_total);
          out_valid              <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    unread_total <= CNT_W'(SLOT_COUNT))
    else $error("message count out of range");
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> $countones(in_use) == unread_total)
    else $error("in-use bits disagree with count");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !take)
    else $error("word accepted while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> out_valid)
    else $error("result not presented");
`endif

endmodule
